>>> rtl/b64d_pkg.sv
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       final_char;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
    logic [1:0] status;
  } b64d_out_t;

  // one decoded group waiting for byte emission
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
    logic        last;
    logic [1:0]  status;
  } b64d_rec_t;

endpackage

>>> rtl/b64d_front.sv
module b64d_front
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  b64d_in_t  in_data,
  input  logic      q_full,
  output logic      in_stall,
  output logic      push,
  output b64d_rec_t push_rec
);

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        bad_r, bad_nxt;
  logic        third_pad_r, third_pad_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [7:0]  diff;
  logic [5:0]  v;
  logic        char_ok;
  logic        is_pad;
  logic        last;
  logic        bad_any;
  logic [1:0]  drops;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c        = in_data.char_in;
  assign last     = in_data.final_char;
  assign is_pad   = (c == PAD_CHAR);

  // alphabet lookup
  always_comb begin
    char_ok = 1'b1;
    diff    = 8'd0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      diff = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      diff = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      diff = c + 8'h04;
    end else if (c == 8'h2B) begin
      diff = 8'd62;
    end else if (c == 8'h2F) begin
      diff = 8'd63;
    end else if (is_pad) begin
      diff = 8'd0;
    end else begin
      diff    = 8'd0;
      char_ok = 1'b0;
    end
    v = diff[5:0];
  end

  always_comb begin
    bad_any = bad_r | ~char_ok;
    drops   = {1'b0, last & is_pad} + {1'b0, last & third_pad_r};

    push     = accept && ((pos_r == 2'd3) || last);
    push_rec = '0;
    if (pos_r == 2'd3) begin
      push_rec.word   = {acc_r, v};
      push_rec.count  = 2'd3 - drops;
      push_rec.last   = last;
      push_rec.status = (last && bad_any) ? STATUS_BAD_CHAR : STATUS_OK;
    end else begin
      // final character inside an open group
      push_rec.word   = 24'd0;
      push_rec.count  = 2'd1;
      push_rec.last   = 1'b1;
      push_rec.status = STATUS_BAD_LEN;
    end

    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    bad_nxt       = bad_r;
    third_pad_nxt = third_pad_r;
    if (accept) begin
      bad_nxt = bad_any;
      if (pos_r == 2'd3) begin
        acc_nxt       = 18'd0;
        pos_nxt       = 2'd0;
        third_pad_nxt = 1'b0;
      end else begin
        acc_nxt = {acc_r[11:0], v};
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd2) begin
          third_pad_nxt = is_pad;
        end
      end
      if (last) begin
        acc_nxt       = 18'd0;
        pos_nxt       = 2'd0;
        bad_nxt       = 1'b0;
        third_pad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 18'd0;
      pos_r       <= 2'd0;
      bad_r       <= 1'b0;
      third_pad_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      bad_r       <= bad_nxt;
      third_pad_r <= third_pad_nxt;
    end
  end

  a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> pos_r == 2'd0 && !bad_r && !third_pad_r)
    else $error("front state not cleared after final character");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_rec.count != 2'd0)
    else $error("group pushed with no bytes");

endmodule

>>> rtl/b64d_queue.sv
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64d_rec_t push_rec,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output b64d_rec_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_rec_t          slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

>>> rtl/b64d_back.sv
module b64d_back
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  b64d_rec_t q_head,
  output logic      pop,
  output logic      out_valid,
  output b64d_out_t out_data,
  input  logic      out_stall
);

  b64d_rec_t  cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       is_last_byte;
  logic       take;

  assign out_valid    = cur_valid_r;
  assign is_last_byte = (idx_r == cur_r.count - 2'd1);
  assign take         = cur_valid_r && !out_stall;

  always_comb begin
    unique case (idx_r)
      2'd0:    out_data.data_byte = cur_r.word[23:16];
      2'd1:    out_data.data_byte = cur_r.word[15:8];
      default: out_data.data_byte = cur_r.word[7:0];
    endcase
    out_data.final_byte = cur_r.last && is_last_byte;
    out_data.status     = out_data.final_byte ? cur_r.status : STATUS_OK;
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    if (!cur_valid_r || (take && is_last_byte)) begin
      // current group done or none held: load the next one
      pop           = q_not_empty;
      cur_valid_nxt = q_not_empty;
      idx_nxt       = 2'd0;
      if (q_not_empty) begin
        cur_nxt = q_head;
      end
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> cur_r.count != 2'd0 && idx_r < cur_r.count)
    else $error("byte index outside group");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && out_stall |=> cur_valid_r && $stable(idx_r))
    else $error("result changed while stalled");

endmodule

>>> rtl/base64_decoder_unit.sv
// Base64 text decoder. Takes one character per cycle and returns decoded bytes one per
// cycle while out_stall is low; each group of four characters yields three bytes (fewer
// for trailing pads in the final group). The front end decodes and packs characters into
// 24-bit groups, a QUEUE_DEPTH entry group queue decouples it from the back end, which
// serializes one byte per cycle. Input stalls only while the group queue is full. The
// last result of a stream carries the status: ok, invalid character seen, or length not
// a multiple of four (one zero byte in that case).
module base64_decoder_unit
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  b64d_in_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output b64d_out_t out_data,
  input  logic      out_stall
);

  logic      push;
  b64d_rec_t push_rec;
  logic      pop;
  logic      q_full;
  logic      q_not_empty;
  b64d_rec_t q_head;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_rec (push_rec)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule
